FILE: rtl/bfa_pkg.sv
// Shared types and constants of the bitmap fixed-size block allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bfa_pkg;

   // Operation codes carried on the request tuser field.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NO_MEMORY  = 3'd1;
   localparam logic [2:0] ST_BAD_ADDR   = 3'd2;
   localparam logic [2:0] ST_NOT_ALLOC  = 3'd3;
   localparam logic [2:0] ST_SIZE_LARGE = 3'd4;

   // Register indexes of the configuration port (byte address = 4 * index).
   localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
   localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

   // The occupancy map is stored as words of this many bits.
   localparam int MAP_WORD      = 32;
   localparam int MAP_WORD_BITS = 5;

   typedef struct packed {
      logic [31:0] base_address;
      logic [15:0] block_size;
      logic [8:0]  block_count;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       clear_step;
      logic       load_item;
      logic       scan_init;
      logic       scan_next;
      logic       map_read;
      logic       read_sel;     // 0: scan pointer, 1: word of the block index
      logic       scan_take;
      logic       mul_sel;      // 0: count times size, 1: index times size
      logic       add_go;
      logic       div_init;
      logic       div_step;
      logic       free_bit;
      logic       set_status;
      logic [2:0] status_code;
      logic       set_live;
      logic       out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       clear_last;
      logic [1:0] opcode;
      logic       oversize;
      logic       count_zero;
      logic       found;
      logic       scan_last;
      logic       out_of_range;
      logic       div_last;
      logic       rem_nonzero;
      logic       idx_bit;
      logic       rsp_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: rtl/bfa_csr.sv
// Configuration registers of the block allocator behind an APB-style port.
// Depends on bfa_pkg for the register indexes and the configuration struct.
`default_nettype none

module bfa_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [3:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic      [31:0]     csr_prdata,
   output logic                 csr_pready,
   output bfa_pkg::cfg_type     cfg
);
   import bfa_pkg::*;

   logic [31:0] base_ff, base_in;
   logic [15:0] bsize_ff, bsize_in;
   logic [8:0]  bcount_ff, bcount_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      base_in   = base_ff;
      bsize_in  = bsize_ff;
      bcount_in = bcount_ff;
      if (wr_en) begin
         case (csr_paddr[3:2])
            REG_BASE_ADDRESS: base_in   = csr_pwdata;
            REG_BLOCK_SIZE:   bsize_in  = csr_pwdata[15:0];
            REG_BLOCK_COUNT:  bcount_in = csr_pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= 32'd0;
         bsize_ff  <= 16'd64;
         bcount_ff <= 9'd256;
      end else begin
         base_ff   <= base_in;
         bsize_ff  <= bsize_in;
         bcount_ff <= bcount_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_BASE_ADDRESS: csr_prdata = base_ff;
         REG_BLOCK_SIZE:   csr_prdata = {16'd0, bsize_ff};
         REG_BLOCK_COUNT:  csr_prdata = {23'd0, bcount_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.base_address = base_ff;
   assign cfg.block_size   = bsize_ff;
   assign cfg.block_count  = bcount_ff;

endmodule

`default_nettype wire

FILE: rtl/bfa_ctrl.sv
// Controller state machine of the block allocator: sequences clear, scan,
// multiply, divide and map accesses. Depends on bfa_pkg for the command types.
`default_nettype none

module bfa_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire bfa_pkg::ctrl_status_type st,
   output bfa_pkg::ctrl_cmd_type         cmd
);
   import bfa_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DECODE    = 4'd2;
   localparam logic [3:0] S_SCAN_RD   = 4'd3;
   localparam logic [3:0] S_SCAN_CHK  = 4'd4;
   localparam logic [3:0] S_ALLOC_MUL = 4'd5;
   localparam logic [3:0] S_ALLOC_ADD = 4'd6;
   localparam logic [3:0] S_LIMIT     = 4'd7;
   localparam logic [3:0] S_DIV       = 4'd8;
   localparam logic [3:0] S_DIV_CHK   = 4'd9;
   localparam logic [3:0] S_BIT       = 4'd10;
   localparam logic [3:0] S_FINISH    = 4'd11;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (st.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (st.opcode)
               OP_ALLOC: begin
                  if (st.oversize) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_SIZE_LARGE;
                     state_in        = S_FINISH;
                  end else if (st.count_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_NO_MEMORY;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN_RD;
                  end
               end
               OP_FREE, OP_QUERY: begin
                  if (st.count_zero) begin
                     cmd.set_status  = (st.opcode == OP_FREE);
                     cmd.status_code = ST_BAD_ADDR;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.mul_sel = 1'b0;
                     state_in    = S_LIMIT;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_SCAN_RD: begin
            cmd.map_read = 1'b1;
            cmd.read_sel = 1'b0;
            state_in     = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (st.found) begin
               cmd.scan_take = 1'b1;
               state_in      = S_ALLOC_MUL;
            end else if (st.scan_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NO_MEMORY;
               state_in        = S_FINISH;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_ALLOC_MUL: begin
            cmd.mul_sel = 1'b1;
            state_in    = S_ALLOC_ADD;
         end
         S_ALLOC_ADD: begin
            cmd.add_go = 1'b1;
            state_in   = S_FINISH;
         end
         S_LIMIT: begin
            if (st.out_of_range) begin
               cmd.set_status  = (st.opcode == OP_FREE);
               cmd.status_code = ST_BAD_ADDR;
               state_in        = S_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) state_in = S_DIV_CHK;
         end
         S_DIV_CHK: begin
            if (st.rem_nonzero) begin
               cmd.set_status  = (st.opcode == OP_FREE);
               cmd.status_code = ST_BAD_ADDR;
               state_in        = S_FINISH;
            end else begin
               cmd.map_read = 1'b1;
               cmd.read_sel = 1'b1;
               state_in     = S_BIT;
            end
         end
         S_BIT: begin
            if (st.opcode == OP_FREE) begin
               if (st.idx_bit) begin
                  cmd.free_bit = 1'b1;
               end else begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_NOT_ALLOC;
               end
            end else begin
               cmd.set_live = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (st.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

FILE: rtl/bfa_datapath.sv
// Datapath of the block allocator: occupancy map memory, word scan, multiplier,
// restoring divider and the result register. Depends on bfa_pkg.
`default_nettype none

module bfa_datapath #(
   parameter int MAX_BLOCKS = 256,
   parameter int ADDR_BITS  = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bfa_pkg::cfg_type      cfg,
   input  wire bfa_pkg::ctrl_cmd_type cmd,
   output bfa_pkg::ctrl_status_type   st,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [31:0]           req_address,
   input  wire logic [15:0]           req_request_size,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [31:0]                rsp_block_address,
   output logic                       rsp_is_live
);
   import bfa_pkg::*;

   localparam int NW  = (MAX_BLOCKS + MAP_WORD - 1) / MAP_WORD;
   localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int QW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int GW  = (CW > WIW + MAP_WORD_BITS) ? CW : WIW + MAP_WORD_BITS;
   localparam int PW  = CW + 16;
   localparam int LW  = (ADDR_BITS > PW) ? ADDR_BITS : PW;
   localparam int RW  = QW + 17;
   localparam int KW  = (QW > 1) ? $clog2(QW) : 1;
   localparam int EW  = (CW > 9) ? CW : 9;

   logic [MAP_WORD-1:0] map_mem [NW];
   logic [MAP_WORD-1:0] map_rdata_ff;

   logic [WIW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [WIW-1:0]  scan_ptr_ff, scan_ptr_in;
   logic [1:0]      opcode_ff, opcode_in;
   logic [31:0]     address_ff, address_in;
   logic [15:0]     request_ff, request_in;
   logic [QW-1:0]   idx_ff, idx_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [KW-1:0]   div_k_ff, div_k_in;
   logic [PW-1:0]   product_ff, product_in;
   logic [2:0]      status_ff, status_in;
   logic [31:0]     baddr_ff, baddr_in;
   logic            live_ff, live_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [31:0]     rsp_baddr_ff, rsp_baddr_in;
   logic            rsp_live_ff, rsp_live_in;

   logic [CW-1:0]        count_eff;
   logic [CW-1:0]        mul_a;
   logic [GW-1:0]        count_m1;
   logic [GW-1:0]        gidx;
   logic [WIW-1:0]       idx_word;
   logic [MAP_WORD_BITS-1:0] idx_pos;
   logic [MAP_WORD-1:0]  free_vec;
   logic [MAP_WORD_BITS-1:0] found_pos;
   logic [ADDR_BITS-1:0] offset;
   logic [RW-1:0]        bs_shift;
   logic                 div_ge;
   logic                 map_we;
   logic [WIW-1:0]       map_waddr;
   logic [MAP_WORD-1:0]  map_wdata;
   logic [WIW-1:0]       map_raddr;

   // Blocks in the pool: none when the block size is zero.
   always_comb begin
      if (cfg.block_size == 16'd0)
         count_eff = '0;
      else if (EW'(cfg.block_count) < EW'(MAX_BLOCKS))
         count_eff = CW'(cfg.block_count);
      else
         count_eff = CW'(MAX_BLOCKS);
   end

   assign count_m1 = GW'(count_eff) - GW'(1);
   assign gidx     = GW'(idx_ff);
   assign idx_word = gidx[WIW+MAP_WORD_BITS-1:MAP_WORD_BITS];
   assign idx_pos  = gidx[MAP_WORD_BITS-1:0];
   assign offset   = ADDR_BITS'(address_ff) - ADDR_BITS'(cfg.base_address);
   assign bs_shift = RW'(cfg.block_size) << div_k_ff;
   assign div_ge   = (rem_ff >= bs_shift);
   assign mul_a    = cmd.mul_sel ? CW'(idx_ff) : count_eff;

   // Free blocks of the current scan word that lie inside the pool.
   always_comb begin
      logic [GW-1:0] gi;
      free_vec  = '0;
      found_pos = '0;
      for (int b = 0; b < MAP_WORD; b++) begin
         gi          = GW'({scan_ptr_ff, MAP_WORD_BITS'(b)});
         free_vec[b] = (gi < GW'(count_eff)) && !map_rdata_ff[b];
      end
      for (int b = MAP_WORD - 1; b >= 0; b--) begin
         if (free_vec[b]) found_pos = MAP_WORD_BITS'(b);
      end
   end

   always_comb begin
      map_we    = 1'b0;
      map_waddr = scan_ptr_ff;
      map_wdata = map_rdata_ff;
      if (cmd.clear_step) begin
         map_we    = 1'b1;
         map_waddr = clr_ptr_ff;
         map_wdata = '0;
      end else if (cmd.scan_take) begin
         map_we    = 1'b1;
         map_waddr = scan_ptr_ff;
         map_wdata = map_rdata_ff | (MAP_WORD'(1) << found_pos);
      end else if (cmd.free_bit) begin
         map_we    = 1'b1;
         map_waddr = idx_word;
         map_wdata = map_rdata_ff & ~(MAP_WORD'(1) << idx_pos);
      end
   end

   assign map_raddr = cmd.read_sel ? idx_word : scan_ptr_ff;

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      if (cmd.map_read) map_rdata_ff <= map_mem[map_raddr];
   end

   always_comb begin
      clr_ptr_in    = clr_ptr_ff;
      scan_ptr_in   = scan_ptr_ff;
      opcode_in     = opcode_ff;
      address_in    = address_ff;
      request_in    = request_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      div_k_in      = div_k_ff;
      product_in    = PW'(mul_a) * PW'(cfg.block_size);
      status_in     = status_ff;
      baddr_in      = baddr_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_baddr_in  = rsp_baddr_ff;
      rsp_live_in   = rsp_live_ff;

      if (cmd.clear_step) clr_ptr_in = clr_ptr_ff + WIW'(1);
      if (cmd.load_item) begin
         opcode_in  = req_opcode;
         address_in = req_address;
         request_in = req_request_size;
         status_in  = ST_OK;
         baddr_in   = 32'd0;
         live_in    = 1'b0;
      end
      if (cmd.scan_init) scan_ptr_in = '0;
      if (cmd.scan_next) scan_ptr_in = scan_ptr_ff + WIW'(1);
      if (cmd.scan_take) idx_in = QW'(GW'({scan_ptr_ff, found_pos}));
      if (cmd.div_init) begin
         rem_in   = RW'(offset);
         idx_in   = '0;
         div_k_in = KW'(QW - 1);
      end
      if (cmd.div_step) begin
         div_k_in = div_k_ff - KW'(1);
         if (div_ge) begin
            rem_in = rem_ff - bs_shift;
            idx_in = idx_ff | (QW'(1) << div_k_ff);
         end
      end
      if (cmd.add_go)
         baddr_in = 32'(ADDR_BITS'(cfg.base_address) + ADDR_BITS'(product_ff));
      if (cmd.set_status) status_in = cmd.status_code;
      if (cmd.set_live) live_in = map_rdata_ff[idx_pos];
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_baddr_in  = baddr_ff;
         rsp_live_in   = live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ptr_ff   <= scan_ptr_in;
      opcode_ff     <= opcode_in;
      address_ff    <= address_in;
      request_ff    <= request_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      div_k_ff      <= div_k_in;
      product_ff    <= product_in;
      status_ff     <= status_in;
      baddr_ff      <= baddr_in;
      live_ff       <= live_in;
      rsp_status_ff <= rsp_status_in;
      rsp_baddr_ff  <= rsp_baddr_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign st.clear_last   = (clr_ptr_ff == WIW'(NW - 1));
   assign st.opcode       = opcode_ff;
   assign st.oversize     = (request_ff > cfg.block_size);
   assign st.count_zero   = (count_eff == '0);
   assign st.found        = |free_vec;
   assign st.scan_last    = (scan_ptr_ff == count_m1[WIW+MAP_WORD_BITS-1:MAP_WORD_BITS]);
   assign st.out_of_range = (LW'(offset) >= LW'(product_ff));
   assign st.div_last     = (div_k_ff == '0);
   assign st.rem_nonzero  = |rem_ff;
   assign st.idx_bit      = map_rdata_ff[idx_pos];
   assign st.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_baddr_ff;
   assign rsp_is_live       = rsp_live_ff;

endmodule

`default_nettype wire

FILE: rtl/bitmap_fixed_block_allocator.sv
// Top level of the bitmap fixed-size block allocator.
// Instantiates bfa_csr, bfa_ctrl and bfa_datapath; depends on bfa_pkg.
//
// Usage: each request transaction on the req_ stream carries an operation in
// req_tuser (allocate, free, query) and an address and request size in
// req_tdata. Every request produces exactly one response transaction on the
// rsp_ stream with a status, the allocated block address and the query flag.
// Base address, block size and block count are set through the csr_ APB port,
// by the user only while the block is idle (not enforced); pready is always high.
// Allocate does one map memory read and one check per 32-bit map word scanned,
// up to 8 words at 256 blocks. Free and query run the one-bit-per-cycle
// restoring divider that turns the address offset into a block index.
// Requests settled at decode (oversized, empty pool, unused opcode) and a free
// or query past the end of the pool need neither scan nor divider. One request
// is worked on at a time; the next is accepted once the current result sits in
// the output register.
// Reset: the occupancy map is cleared by a pass over its words, one word per
// cycle; no request is accepted until that pass is done. Configuration returns
// to its reset values.
// Stall: when rsp_tready is low the result is held in the output register and
// the next request may already be taken and worked on; it then waits at its
// end until the output register is free.
`default_nettype none

module bitmap_fixed_block_allocator #(
   parameter int MAX_BLOCKS = 256,
   parameter int ADDR_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // address [31:0], request_size [47:32]
   input  wire logic [1:0]  req_tuser,   // opcode [1:0]
   // Response stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // status [2:0], block_address [34:3],
                                         // is_live [35], zero [39:36]
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import bfa_pkg::*;

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type st;
   logic [2:0]      rsp_status;
   logic [31:0]     rsp_block_address;
   logic            rsp_is_live;

   bfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // The datapath captures the request fields when the controller issues
   // load_item, which happens exactly on an accepted request transaction.
   bfa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .st                (st),
      .req_opcode        (req_tuser),
      .req_address       (req_tdata[31:0]),
      .req_request_size  (req_tdata[47:32]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_is_live       (rsp_is_live)
   );

   assign rsp_tdata = {4'd0, rsp_is_live, rsp_block_address, rsp_status};

endmodule

`default_nettype wire
